// File: rtl/core/asd_pkg.sv
`timescale 1ns / 1ps

package asd_pkg;

   // Stream framing constants
   localparam int FRAME_BYTES  = 640;
   localparam int HEADER_BYTES = 8;
   localparam int FOOTER_BYTES = 12;

   localparam logic [7:0] SYNC_FIRST  = 8'h12;
   localparam logic [7:0] SYNC_SECOND = 8'h34;

   // Footer positions that land in one of the three captured words
   localparam logic [3:0] FOOTER_CAPTURE_END = 4'd12;

   // Header positions
   localparam logic [3:0] HDR_POS_ENDPOINT = 4'd2;
   localparam logic [3:0] HDR_POS_RATE     = 4'd3;
   localparam logic [3:0] HDR_POS_LEN_LOW  = 4'd4;
   localparam logic [3:0] HDR_POS_LEN_HIGH = 4'd5;

   // Result kinds carried on rsp_tuser
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_HEADER  = 2'd1;
   localparam logic [1:0] KIND_FOOTER  = 2'd2;

   localparam int RSP_TDATA_BITS = 136;
   localparam int RSP_TUSER_BITS = 2;

   // Work handed from the parser to the record builder
   typedef enum logic [1:0] {
      OP_HEADER,
      OP_PAYLOAD,
      OP_FOOTER
   } asd_op_type;

   typedef struct packed {
      asd_op_type  op;
      logic [3:0]  pos;     // byte position within header or footer
      logic [7:0]  data;
      logic        last;    // header/footer: closes the record; payload: frame end
      logic [10:0] length;  // validated payload length, header bytes only
   } asd_entry_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic        frame_last;
      logic [7:0]  endpoint_num;
      logic [3:0]  sample_rate_code;
      logic [3:0]  packet_count;
      logic        packet_gap;
      logic [10:0] payload_size;
      logic [31:0] current_frame_count;
      logic [31:0] start_index;
      logic [31:0] end_index;
      logic        frame_gap;
   } asd_result_type;

   // Pass a length through only if it is one of the supported sizes
   function automatic logic [10:0] check_length(input logic [15:0] len);
      logic [10:0] res;
      res = '0;
      case (len)
         16'd80, 16'd128, 16'd160, 16'd256, 16'd320,
         16'd480, 16'd512, 16'd640, 16'd1280: res = len[10:0];
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

// File: rtl/core/audio_stream_deframer.sv
`timescale 1ns / 1ps
// Audio stream deframer.
// req_* takes one received UART byte per transfer. The block hunts for the
// sync pair 0x12 0x34, parses the 8-byte header, passes payload bytes on and
// parses the 12-byte footer that follows a payload.
// rsp_* gives one record per transfer: rsp_tuser is the kind (payload byte,
// header record, footer record), rsp_tlast marks the byte that completes a
// 640-byte frame, rsp_tdata carries all other fields (zero where unused).
// Throughput is one byte per cycle while the queue is not full. A byte is
// classified in the parser, written into the queue, and turned into a record
// in the output register behind it.
// A queue of QUEUE_DEPTH entries sits between parser and record builder;
// while rsp_tready is low the output register holds its record and the queue
// fills, and req_tready drops only once the queue is full.
// Reset returns the parser to sync hunting, empties the queue and output
// register, and sets the last packet count to 15 and last frame count to
// all ones.

module audio_stream_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] byte_in
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] payload_byte, [15:8] endpoint_num, [19:16] sample_rate_code,
   // [23:20] packet_count, [24] packet_gap, [35:25] payload_size,
   // [67:36] current_frame_count, [99:68] start_index, [131:100] end_index,
   // [132] frame_gap, [135:133] zero
   output logic [asd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic [asd_pkg::RSP_TUSER_BITS-1:0] rsp_tuser,   // [1:0] result_kind
   output logic                                rsp_tlast    // frame_last
);
   import asd_pkg::*;

   logic           q_full;
   logic           q_push;
   asd_entry_type  q_push_entry;
   logic           q_pop;
   logic           q_valid;
   asd_entry_type  q_entry;
   asd_result_type result;

   asd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   asd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   asd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (result)
   );

   // Pack the record onto the stream
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.frame_last;
   assign rsp_tdata = {3'b000,
                       result.frame_gap,
                       result.end_index,
                       result.start_index,
                       result.current_frame_count,
                       result.payload_size,
                       result.packet_gap,
                       result.packet_count,
                       result.sample_rate_code,
                       result.endpoint_num,
                       result.payload_byte};

`ifndef SYNTH
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("record builder popped an empty queue");

   a_last_only_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_PAYLOAD)
      else $error("frame end flagged on a non-payload record");

   a_record_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_PAYLOAD |-> rsp_tdata[7:0] == 8'h00)
      else $error("header or footer record carries a payload byte");
`endif

endmodule

// File: rtl/core/asd_front.sv
`timescale 1ns / 1ps

module asd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,    // [7:0] byte_in
   input  logic                  q_full,
   output logic                  push,
   output asd_pkg::asd_entry_type push_entry
);
   import asd_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD,
      PH_FOOTER
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  prev_byte_ff, prev_byte_in;
   logic [3:0]  pos_ff, pos_in;
   logic [10:0] left_ff, left_in;
   logic [9:0]  fill_ff, fill_in;
   logic [7:0]  len_low_ff, len_low_in;

   logic        accept;
   logic [4:0]  pos_next;
   logic [10:0] fill_inc;
   logic [10:0] len_now;
   logic        hdr_done;
   logic        ftr_done;
   logic        frame_end;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign pos_next   = {1'b0, pos_ff} + 5'd1;
   assign fill_inc   = {1'b0, fill_ff} + 11'd1;
   assign hdr_done   = pos_next >= 5'(HEADER_BYTES);
   assign ftr_done   = pos_next >= 5'(FOOTER_BYTES);
   assign frame_end  = fill_inc >= 11'(FRAME_BYTES);
   assign len_now    = (pos_ff == HDR_POS_LEN_HIGH) ?
                       check_length({req_tdata, len_low_ff}) : left_ff;

   // Track framing position and classify each received byte
   always_comb begin
      phase_in     = phase_ff;
      prev_byte_in = prev_byte_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      fill_in      = fill_ff;
      len_low_in   = len_low_ff;
      push         = 1'b0;
      push_entry   = '{op: OP_HEADER, pos: pos_ff, data: req_tdata, last: 1'b0,
                       length: '0};
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (prev_byte_ff == SYNC_FIRST && req_tdata == SYNC_SECOND) begin
                  prev_byte_in = '0;
                  pos_in       = HDR_POS_ENDPOINT;
                  phase_in     = PH_HEADER;
               end else begin
                  prev_byte_in = req_tdata;
               end
            end
            PH_HEADER: begin
               push              = 1'b1;
               push_entry.op     = OP_HEADER;
               push_entry.last   = hdr_done;
               push_entry.length = len_now;
               if (pos_ff == HDR_POS_LEN_LOW) begin
                  len_low_in = req_tdata;
               end
               left_in = len_now;
               if (hdr_done) begin
                  pos_in   = '0;
                  phase_in = (len_now != '0) ? PH_PAYLOAD : PH_HUNT;
               end else begin
                  pos_in = pos_next[3:0];
               end
            end
            PH_PAYLOAD: begin
               push            = 1'b1;
               push_entry.op   = OP_PAYLOAD;
               push_entry.last = frame_end;
               fill_in         = frame_end ? '0 : fill_inc[9:0];
               left_in         = left_ff - 11'd1;
               if (left_ff == 11'd1) begin
                  pos_in   = '0;
                  phase_in = PH_FOOTER;
               end
            end
            PH_FOOTER: begin
               push            = 1'b1;
               push_entry.op   = OP_FOOTER;
               push_entry.last = ftr_done;
               if (ftr_done) begin
                  pos_in       = '0;
                  prev_byte_in = '0;
                  phase_in     = PH_HUNT;
               end else begin
                  pos_in = pos_next[3:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         prev_byte_ff <= '0;
         pos_ff       <= '0;
         left_ff      <= '0;
         fill_ff      <= '0;
         len_low_ff   <= '0;
      end else begin
         phase_ff     <= phase_in;
         prev_byte_ff <= prev_byte_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         fill_ff      <= fill_in;
         len_low_ff   <= len_low_in;
      end
   end

endmodule

// File: rtl/core/asd_queue.sv
`timescale 1ns / 1ps

module asd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  asd_pkg::asd_entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output asd_pkg::asd_entry_type pop_entry
);
   import asd_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   asd_entry_type       store_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                do_push;
   logic                do_pop;

   assign full      = cnt_ff == CNT_BITS'(DEPTH);
   assign pop_valid = cnt_ff != '0;
   assign pop_entry = store_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/asd_back.sv
`timescale 1ns / 1ps

module asd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  asd_pkg::asd_entry_type  q_entry,
   output logic                   q_pop,
   input  logic                   rsp_tready,
   output logic                   rsp_valid,
   output asd_pkg::asd_result_type rsp_result
);
   import asd_pkg::*;

   logic [7:0]     endpoint_ff, endpoint_in;
   logic [7:0]     rate_byte_ff, rate_byte_in;
   logic [31:0]    word_ff [3];
   logic [31:0]    word_in [3];
   logic [3:0]     last_pc_ff, last_pc_in;
   logic [31:0]    last_fc_ff, last_fc_in;
   logic           valid_ff, valid_in;
   asd_result_type result_ff, result_in;

   logic           emits;
   logic           out_free;

   assign emits      = (q_entry.op == OP_PAYLOAD) || q_entry.last;
   assign out_free   = !valid_ff || rsp_tready;
   assign q_pop      = q_valid && (!emits || out_free);
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   // Merge the current footer byte into the captured words
   always_comb begin
      for (int w = 0; w < 3; w++) begin
         word_in[w] = word_ff[w];
      end
      if (q_pop && q_entry.op == OP_FOOTER && q_entry.pos < FOOTER_CAPTURE_END) begin
         for (int w = 0; w < 3; w++) begin
            for (int l = 0; l < 4; l++) begin
               if (q_entry.pos[3:2] == 2'(w) && q_entry.pos[1:0] == 2'(l)) begin
                  word_in[w][8*l +: 8] = q_entry.data;
               end
            end
         end
      end
   end

   // Build records and load the output register
   always_comb begin
      endpoint_in  = endpoint_ff;
      rate_byte_in = rate_byte_ff;
      last_pc_in   = last_pc_ff;
      last_fc_in   = last_fc_ff;
      result_in    = result_ff;
      valid_in     = valid_ff && !rsp_tready;
      if (q_pop) begin
         case (q_entry.op)
            OP_HEADER: begin
               if (q_entry.pos == HDR_POS_ENDPOINT) begin
                  endpoint_in = q_entry.data;
               end
               if (q_entry.pos == HDR_POS_RATE) begin
                  rate_byte_in = q_entry.data;
               end
               if (q_entry.last) begin
                  result_in                  = '0;
                  result_in.kind             = KIND_HEADER;
                  result_in.endpoint_num     = endpoint_ff;
                  result_in.sample_rate_code = rate_byte_ff[7:4];
                  result_in.packet_count     = rate_byte_ff[3:0];
                  result_in.packet_gap       = rate_byte_ff[3:0] != last_pc_ff + 4'd1;
                  result_in.payload_size     = q_entry.length;
                  last_pc_in                 = rate_byte_ff[3:0];
                  valid_in                   = 1'b1;
               end
            end
            OP_PAYLOAD: begin
               result_in              = '0;
               result_in.kind         = KIND_PAYLOAD;
               result_in.payload_byte = q_entry.data;
               result_in.frame_last   = q_entry.last;
               valid_in               = 1'b1;
            end
            OP_FOOTER: begin
               if (q_entry.last) begin
                  result_in                     = '0;
                  result_in.kind                = KIND_FOOTER;
                  result_in.current_frame_count = word_in[0];
                  result_in.start_index         = {word_in[2][23:0], 8'h00};
                  result_in.end_index           = {word_in[1][23:0], 8'h00};
                  result_in.frame_gap           = word_in[0] != last_fc_ff + 32'd1;
                  last_fc_in                    = word_in[0];
                  valid_in                      = 1'b1;
               end
            end
            default: begin
               valid_in = valid_ff && !rsp_tready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         last_pc_ff <= 4'hF;
         last_fc_ff <= '1;
      end else begin
         valid_ff   <= valid_in;
         last_pc_ff <= last_pc_in;
         last_fc_ff <= last_fc_in;
      end
   end

   // Captured fields and record payload
   always_ff @(posedge clock) begin
      endpoint_ff  <= endpoint_in;
      rate_byte_ff <= rate_byte_in;
      result_ff    <= result_in;
      for (int w = 0; w < 3; w++) begin
         word_ff[w] <= word_in[w];
      end
   end

endmodule

// File: dv/tb_audio_stream_deframer.sv
`timescale 1ns / 1ps

module tb_audio_stream_deframer;
   import asd_pkg::*;

   localparam int CYCLE_LIMIT      = 400_000;
   localparam int DRAIN_CYCLES     = 20;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS     = 1000;

   typedef enum logic [1:0] {
      HUNTING,
      IN_HEADER,
      IN_PAYLOAD,
      IN_FOOTER
   } parse_phase_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [RSP_TUSER_BITS-1:0] rsp_tuser;
   logic                      rsp_tlast;

   // Parser state as the stream has left it so far
   parse_phase_type rx_phase    = HUNTING;
   logic [7:0]   prev_rx_byte   = '0;
   logic [3:0]   field_pos      = '0;
   logic [10:0]  bytes_left     = '0;
   logic [9:0]   frame_fill_cnt = '0;
   logic [7:0]   hdr_endpoint   = '0;
   logic [7:0]   hdr_rate_cnt   = '0;
   logic [7:0]   hdr_len_low    = '0;
   logic [31:0]  ftr_words [3]  = '{default: '0};
   logic [3:0]   last_pkt_cnt   = 4'd15;
   logic [31:0]  last_frame_cnt = '1;

   asd_result_type expected_records [$];
   int unsigned    mismatches = 0;
   int unsigned    bytes_sent = 0;
   bit             req_idle_on = 1'b0;
   bit             rsp_idle_on = 1'b0;
   int unsigned    long_hold = 0;

   audio_stream_deframer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Advance the parser by one received byte; return 1 with the record it produces
   function automatic bit deframe_byte(input logic [7:0] b, output asd_result_type rec);
      logic [15:0] len;
      logic [3:0]  pc;
      bit          emit;
      rec  = '0;
      emit = 1'b0;
      case (rx_phase)
         HUNTING: begin
            if (prev_rx_byte == SYNC_FIRST && b == SYNC_SECOND) begin
               prev_rx_byte = '0;
               field_pos    = HDR_POS_ENDPOINT;
               rx_phase     = IN_HEADER;
            end else begin
               prev_rx_byte = b;
            end
         end
         IN_HEADER: begin
            if (field_pos == HDR_POS_ENDPOINT) begin
               hdr_endpoint = b;
            end else if (field_pos == HDR_POS_RATE) begin
               hdr_rate_cnt = b;
            end else if (field_pos == HDR_POS_LEN_LOW) begin
               hdr_len_low = b;
            end else if (field_pos == HDR_POS_LEN_HIGH) begin
               len = {b, hdr_len_low};
               case (len)
                  16'd80, 16'd128, 16'd160, 16'd256, 16'd320,
                  16'd480, 16'd512, 16'd640, 16'd1280: bytes_left = len[10:0];
                  default: bytes_left = '0;
               endcase
            end
            if (field_pos == HEADER_BYTES - 1) begin
               pc                   = hdr_rate_cnt[3:0];
               rec.kind             = KIND_HEADER;
               rec.endpoint_num     = hdr_endpoint;
               rec.sample_rate_code = hdr_rate_cnt[7:4];
               rec.packet_count     = pc;
               rec.packet_gap       = (pc != last_pkt_cnt + 4'd1);
               rec.payload_size     = bytes_left;
               last_pkt_cnt         = pc;
               field_pos            = '0;
               rx_phase             = (bytes_left != 0) ? IN_PAYLOAD : HUNTING;
               emit                 = 1'b1;
            end else begin
               field_pos = field_pos + 4'd1;
            end
         end
         IN_PAYLOAD: begin
            frame_fill_cnt   = frame_fill_cnt + 10'd1;
            rec.kind         = KIND_PAYLOAD;
            rec.payload_byte = b;
            // frame boundaries run on across packets
            if (frame_fill_cnt == FRAME_BYTES) begin
               rec.frame_last = 1'b1;
               frame_fill_cnt = '0;
            end
            bytes_left = bytes_left - 11'd1;
            if (bytes_left == 0) begin
               field_pos = '0;
               rx_phase  = IN_FOOTER;
            end
            emit = 1'b1;
         end
         default: begin
            ftr_words[field_pos[3:2]][field_pos[1:0]*8 +: 8] = b;
            if (field_pos == FOOTER_BYTES - 1) begin
               rec.kind                = KIND_FOOTER;
               rec.current_frame_count = ftr_words[0];
               rec.start_index         = ftr_words[2] << 8;
               rec.end_index           = ftr_words[1] << 8;
               rec.frame_gap           = (ftr_words[0] != last_frame_cnt + 32'd1);
               last_frame_cnt          = ftr_words[0];
               field_pos               = '0;
               prev_rx_byte            = '0;
               rx_phase                = HUNTING;
               emit                    = 1'b1;
            end else begin
               field_pos = field_pos + 4'd1;
            end
         end
      endcase
      return emit;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Offer one byte after a random gap and hold it until the transfer
   task automatic send_byte(input logic [7:0] b);
      int unsigned    gap;
      asd_result_type rec;
      gap = req_idle_on ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      if (deframe_byte(b, rec))
         expected_records.push_back(rec);
      bytes_sent++;
   endtask

   // Send sync and header, then as much payload and footer as the header calls for
   task automatic send_packet(input logic [7:0] ep, input logic [7:0] rate_cnt,
                              input logic [15:0] len, input logic [31:0] cur,
                              input logic [31:0] end_cnt, input logic [31:0] start_cnt);
      logic [95:0] footer;
      footer = {start_cnt, end_cnt, cur};
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(ep);
      send_byte(rate_cnt);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      while (rx_phase == IN_PAYLOAD)
         send_byte(8'($urandom));
      if (rx_phase == IN_FOOTER) begin
         for (int i = 0; i < FOOTER_BYTES; i++)
            send_byte(footer[8*i +: 8]);
      end
   endtask

   // False starts, a split sync, invalid lengths and sync bytes in the header tail
   task automatic test_sync_hunt();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_byte(SYNC_SECOND);
      send_byte(SYNC_FIRST);
      send_byte(8'h00);
      send_byte(SYNC_SECOND);
      send_byte(8'hFF);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_packet(8'h00, 8'h00, 16'h0000, '0, '0, '0);
      send_packet(8'h5A, 8'hA1, 16'd81, '0, '0, '0);
   endtask

   // Full packets with extreme footer counters and a sync byte closing a footer
   task automatic test_packet_extremes();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_packet(8'h00, 8'h02, 16'd80, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678);
      send_byte(SYNC_SECOND);
      send_packet(8'hFF, 8'hF7, 16'd128, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
   endtask

   // Hold the receiver off while payload streams in back to back
   task automatic test_backpressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      long_hold   = LONG_HOLD_CYCLES;
      send_packet(8'h3C, {4'h9, last_pkt_cnt + 4'd1}, 16'd320, last_frame_cnt + 32'd1,
                  32'($urandom), 32'($urandom));
   endtask

   // Mostly well-formed packets with random content, plus noise and cut-off headers
   task automatic test_random_stream();
      int unsigned start_count;
      int unsigned sel;
      logic [15:0] len;
      logic [3:0]  pc;
      logic [31:0] cur;
      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_ITEMS) begin
         sel         = $urandom_range(0, 3);
         req_idle_on = sel[0];
         rsp_idle_on = sel[1];
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
         sel = $urandom_range(0, 99);
         if (sel < 12) begin
            len = 16'($urandom);
         end else if (sel < 25) begin
            case ($urandom_range(0, 3))
               0:       len = 16'd79;
               1:       len = 16'd81;
               2:       len = 16'd1281;
               default: len = 16'd0;
            endcase
         end else if (sel < 29) begin
            len = $urandom_range(0, 1) ? 16'd640 : 16'd1280;
         end else if (sel < 45) begin
            case ($urandom_range(0, 3))
               0:       len = 16'd256;
               1:       len = 16'd320;
               2:       len = 16'd480;
               default: len = 16'd512;
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0:       len = 16'd80;
               1:       len = 16'd128;
               default: len = 16'd160;
            endcase
         end
         pc  = ($urandom_range(0, 4) == 0) ? 4'($urandom) : last_pkt_cnt + 4'd1;
         cur = ($urandom_range(0, 4) == 0) ? 32'($urandom) : last_frame_cnt + 32'd1;
         if ($urandom_range(0, 9) == 0) begin
            // cut the header short; the next sync is swallowed as header bytes
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
         end else begin
            send_packet(8'($urandom), {4'($urandom), pc}, len, cur,
                        32'($urandom), 32'($urandom));
         end
      end
   endtask

   // Receiver: random stall before each result, or one long hold when asked
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold != 0) begin
            stall     = long_hold;
            long_hold = 0;
         end else begin
            stall = rsp_idle_on ? $urandom_range(0, 10) : 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each result transfer with the oldest expected record
   always @(posedge clock) begin
      asd_result_type want;
      asd_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got                     = '0;
         got.kind                = rsp_tuser;
         got.payload_byte        = rsp_tdata[7:0];
         got.frame_last          = rsp_tlast;
         got.endpoint_num        = rsp_tdata[15:8];
         got.sample_rate_code    = rsp_tdata[19:16];
         got.packet_count        = rsp_tdata[23:20];
         got.packet_gap          = rsp_tdata[24];
         got.payload_size        = rsp_tdata[35:25];
         got.current_frame_count = rsp_tdata[67:36];
         got.start_index         = rsp_tdata[99:68];
         got.end_index           = rsp_tdata[131:100];
         got.frame_gap           = rsp_tdata[132];
         if (expected_records.size() == 0) begin
            $error("result of kind %0d with none expected", rsp_tuser);
            mismatches++;
         end else begin
            want = expected_records.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("frame_last", want.frame_last, got.frame_last);
            compare_field("endpoint_num", want.endpoint_num, got.endpoint_num);
            compare_field("sample_rate_code", want.sample_rate_code, got.sample_rate_code);
            compare_field("packet_count", want.packet_count, got.packet_count);
            compare_field("packet_gap", want.packet_gap, got.packet_gap);
            compare_field("payload_size", want.payload_size, got.payload_size);
            compare_field("current_frame_count", want.current_frame_count,
                          got.current_frame_count);
            compare_field("start_index", want.start_index, got.start_index);
            compare_field("end_index", want.end_index, got.end_index);
            compare_field("frame_gap", want.frame_gap, got.frame_gap);
         end
      end
   end

   // Stop a hung run
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sync_hunt();
      test_packet_extremes();
      test_backpressure();
      test_random_stream();

      // Drain outstanding results, then watch for strays
      req_tvalid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/asd_pkg.sv
rtl/core/asd_front.sv
rtl/core/asd_queue.sv
rtl/core/asd_back.sv
rtl/core/audio_stream_deframer.sv
dv/tb_audio_stream_deframer.sv
